FILE: src/lar_pkg.sv
// ----------------------------------------------------------------------------
// lar_pkg
// Shared sizes, codes, control structs and helpers for the line assembly
// ring queue.
// ----------------------------------------------------------------------------
package lar_pkg;

   // Ring geometry
   localparam int LINE_COUNT = 8;
   localparam int LINE_LEN   = 32;
   localparam int SLOT_BYTES = LINE_LEN + 1;
   localparam int STORE_DEPTH = LINE_COUNT * SLOT_BYTES;

   localparam int SLOT_W = $clog2(LINE_COUNT);
   localparam int POS_W  = $clog2(LINE_LEN + 1);
   localparam int ADDR_W = $clog2(STORE_DEPTH);
   localparam int BYTE_W = 8;

   // Byte codes
   localparam logic [BYTE_W-1:0] NEWLINE = 8'h0A;
   localparam logic [BYTE_W-1:0] TERM    = 8'h00;

   // Request function codes
   localparam logic FUNC_PUSH = 1'b0;
   localparam logic FUNC_POP  = 1'b1;

   // Pointer update commands from the sequencer
   typedef struct packed {
      logic adv_write;
      logic adv_read;
      logic clr_pos;
      logic inc_pos;
   } ring_cmd_type;

   // Pointer status back to the sequencer
   typedef struct packed {
      logic [SLOT_W-1:0] write_slot;
      logic [SLOT_W-1:0] read_slot;
      logic [POS_W-1:0]  pos;
      logic              full;
      logic              empty;
   } ring_stat_type;

   // Step a slot index around the ring
   function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] slot);
      logic [SLOT_W-1:0] res;
      if (slot == SLOT_W'(LINE_COUNT - 1)) begin
         res = '0;
      end else begin
         res = slot + SLOT_W'(1);
      end
      return res;
   endfunction

   // Flat store address of a byte within a slot
   function automatic logic [ADDR_W-1:0] store_addr(input logic [SLOT_W-1:0] slot,
                                                    input logic [POS_W-1:0]  pos);
      logic [ADDR_W-1:0] res;
      res = ADDR_W'(slot) * ADDR_W'(SLOT_BYTES) + ADDR_W'(pos);
      return res;
   endfunction

endpackage

FILE: src/lar_ram.sv
// ----------------------------------------------------------------------------
// lar_ram
// Generic single-clock RAM, one write port and one read port, registered read.
// ----------------------------------------------------------------------------
module lar_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one entry, read one entry every cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/lar_ring.sv
// ----------------------------------------------------------------------------
// lar_ring
// Ring pointers: slot under assembly, oldest complete slot, and the byte
// position in the line being assembled. Reports full and empty.
// ----------------------------------------------------------------------------
module lar_ring import lar_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  ring_cmd_type  cmd,
   output ring_stat_type stat
);

   logic [SLOT_W-1:0] write_slot_ff, write_slot_in;
   logic [SLOT_W-1:0] read_slot_ff, read_slot_in;
   logic [POS_W-1:0]  char_pos_ff, char_pos_in;
   logic [POS_W-1:0]  pos_eff;

   // Clamp the position to the line length
   assign pos_eff = (char_pos_ff > POS_W'(LINE_LEN)) ? POS_W'(LINE_LEN) : char_pos_ff;

   // Next pointer values
   always_comb begin
      write_slot_in = cmd.adv_write ? next_slot(write_slot_ff) : write_slot_ff;
      read_slot_in  = cmd.adv_read  ? next_slot(read_slot_ff)  : read_slot_ff;
      if (cmd.clr_pos) begin
         char_pos_in = '0;
      end else if (cmd.inc_pos) begin
         char_pos_in = pos_eff + POS_W'(1);
      end else begin
         char_pos_in = char_pos_ff;
      end
   end

   // Hold pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         write_slot_ff <= '0;
         read_slot_ff  <= '0;
         char_pos_ff   <= '0;
      end else begin
         write_slot_ff <= write_slot_in;
         read_slot_ff  <= read_slot_in;
         char_pos_ff   <= char_pos_in;
      end
   end

   // Status
   always_comb begin
      stat.write_slot = write_slot_ff;
      stat.read_slot  = read_slot_ff;
      stat.pos        = pos_eff;
      stat.full       = (next_slot(write_slot_ff) == read_slot_ff);
      stat.empty      = (write_slot_ff == read_slot_ff);
   end

endmodule

FILE: src/line_assembly_ring_queue_top.sv
// ----------------------------------------------------------------------------
// line_assembly_ring_queue_top
// Assembles received bytes into text lines in a ring of line slots and
// streams out the oldest complete line on request.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive req_func/req_rx_byte with start; the beat is taken
//   on a clock edge where start is high and busy is low. Push (func 0) stores
//   a byte; a newline or a byte arriving at a full line ends the line, writes
//   the terminator, and commits the line (or drops it with overrun when the
//   ring is full). Pop (func 1) streams the oldest line up to its terminator.
//   Response channel: each result beat is on the rsp_ ports for one cycle
//   with rsp_strobe high; rsp_last marks the final beat of a request. The
//   receiver cannot stall; every beat must be taken when presented.
//   Sequence: a push, or a pop on an empty ring, holds busy high in S_ACK;
//   its single beat is registered as S_ACK ends, and the next request can
//   be taken in the cycle that beat is shown. A pop steps through S_RD and
//   S_DATA for each result byte (terminator included) with busy high; each
//   beat is registered as S_DATA ends, and the next request can be taken in
//   the cycle the last beat is shown: each byte is a read of the line store
//   in S_RD and its registered data in S_DATA, so the RAM read sets the pace.
//   Reset: pointers clear and the ring is empty; no clearing pass is run,
//   since a pop only reads bytes written while its line was assembled.
// ----------------------------------------------------------------------------
module line_assembly_ring_queue_top import lar_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic              req_func,
   input  logic [BYTE_W-1:0] req_rx_byte,
   output logic              rsp_strobe,
   output logic [BYTE_W-1:0] rsp_line_byte,
   output logic              rsp_has_data,
   output logic              rsp_last,
   output logic              rsp_queue_full,
   output logic              rsp_queue_empty,
   output logic              rsp_overrun
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_ACK,
      S_RD,
      S_DATA
   } state_type;

   state_type         state_ff;
   logic              ovr_ff;
   logic [SLOT_W-1:0] base_ff;
   logic [POS_W-1:0]  n_ff;

   logic              rsp_strobe_ff;
   logic [BYTE_W-1:0] rsp_line_byte_ff;
   logic              rsp_has_data_ff;
   logic              rsp_last_ff;
   logic              rsp_full_ff;
   logic              rsp_empty_ff;
   logic              rsp_overrun_ff;

   ring_cmd_type      cmd;
   ring_stat_type     stat;

   logic              accept;
   logic              push_go;
   logic              line_end;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [BYTE_W-1:0] wr_data;
   logic [ADDR_W-1:0] rd_addr;
   logic [BYTE_W-1:0] rd_data;
   logic [BYTE_W-1:0] pop_byte;

   lar_ring u_ring (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .stat  (stat)
   );

   lar_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Decode the accepted beat
   assign busy     = (state_ff != S_IDLE);
   assign accept   = start && !busy;
   assign push_go  = accept && (req_func == FUNC_PUSH);
   assign line_end = (req_rx_byte == NEWLINE) || (stat.pos == POS_W'(LINE_LEN));

   // Store the pushed byte, or the terminator at a line end
   assign wr_en   = push_go;
   assign wr_addr = store_addr(stat.write_slot, stat.pos);
   assign wr_data = line_end ? TERM : req_rx_byte;
   assign rd_addr = store_addr(base_ff, n_ff);

   // Force the terminator at the last position of a slot
   assign pop_byte = (n_ff == POS_W'(LINE_LEN)) ? TERM : rd_data;

   // Pointer commands
   always_comb begin
      cmd.adv_write = push_go && line_end && !stat.full;
      cmd.clr_pos   = push_go && line_end;
      cmd.inc_pos   = push_go && !line_end;
      cmd.adv_read  = accept && (req_func == FUNC_POP) && !stat.empty;
   end

   // Sequencer and response registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_strobe_ff <= 1'b0;
         ovr_ff        <= 1'b0;
         n_ff          <= '0;
         base_ff       <= '0;
      end else begin
         rsp_strobe_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  if (req_func == FUNC_PUSH) begin
                     ovr_ff   <= line_end && stat.full;
                     state_ff <= S_ACK;
                  end else if (stat.empty) begin
                     ovr_ff   <= 1'b0;
                     state_ff <= S_ACK;
                  end else begin
                     base_ff  <= stat.read_slot;
                     n_ff     <= '0;
                     state_ff <= S_RD;
                  end
               end
            end
            S_ACK: begin
               rsp_strobe_ff    <= 1'b1;
               rsp_line_byte_ff <= TERM;
               rsp_has_data_ff  <= 1'b0;
               rsp_last_ff      <= 1'b1;
               rsp_full_ff      <= stat.full;
               rsp_empty_ff     <= stat.empty;
               rsp_overrun_ff   <= ovr_ff;
               state_ff         <= S_IDLE;
            end
            S_RD: begin
               state_ff <= S_DATA;
            end
            S_DATA: begin
               rsp_strobe_ff    <= 1'b1;
               rsp_line_byte_ff <= pop_byte;
               rsp_has_data_ff  <= 1'b1;
               rsp_last_ff      <= (pop_byte == TERM);
               rsp_full_ff      <= stat.full;
               rsp_empty_ff     <= stat.empty;
               rsp_overrun_ff   <= 1'b0;
               if (pop_byte == TERM) begin
                  state_ff <= S_IDLE;
               end else begin
                  n_ff     <= n_ff + POS_W'(1);
                  state_ff <= S_RD;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_line_byte   = rsp_line_byte_ff;
   assign rsp_has_data    = rsp_has_data_ff;
   assign rsp_last        = rsp_last_ff;
   assign rsp_queue_full  = rsp_full_ff;
   assign rsp_queue_empty = rsp_empty_ff;
   assign rsp_overrun     = rsp_overrun_ff;

   // Checks
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted request did not raise busy");

   a_full_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !(rsp_queue_full && rsp_queue_empty))
      else $error("ring reported full and empty together");

   a_term_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_has_data && (rsp_line_byte == TERM)) |-> rsp_last)
      else $error("terminator beat not marked last");

   a_overrun: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_overrun) |-> (!rsp_has_data && rsp_queue_full))
      else $error("overrun reported without a full ring");

endmodule
